@@ sv/cma_pkg.sv @@
// Shared types, command codes and defaults for the confusion matrix accumulator.
package cma_pkg;

   localparam int MAX_CLASSES_DEFAULT = 16;
   localparam int COUNT_BITS_DEFAULT  = 16;

   localparam logic [4:0] CLASS_COUNT_RESET = 5'd16;

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CELL   = 1'b1;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] score;
      logic               label_hot;
      logic [3:0]         read_row;
      logic [3:0]         read_col;
   } req_payload_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  predicted_index;
      logic [3:0]  label_index;
      logic        label_valid;
      logic [15:0] cell_count;
      logic [15:0] correct_total;
      logic [15:0] sample_total;
   } rsp_payload_type;

endpackage

@@ sv/cma_req_if.sv @@
// Request channel interface: valid, ready and one sample element or command.
interface cma_req_if import cma_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ sv/cma_rsp_if.sv @@
// Response channel interface: valid, ready and one sample report or cell read.
interface cma_rsp_if import cma_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ sv/cma_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module cma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/confusion_matrix_accumulator.sv @@
// Top level: streaming argmax, confusion matrix in RAM, sample and correct counters.
//
//   channel   direction   handshake          content
//   req_ch    in          valid/ready        cmd, score, label_hot, read_row, read_col
//   rsp_ch    out         valid/ready        sample report or cell read data
//   csr_*     in          write enable only  class_count
//
// A sample element that does not end a sample leaves the block idle and ready for the
// next element. A read and the last element of a sample go through the accept cycle,
// which starts the RAM read, and a result cycle, which writes back and loads the output
// register; a waiting response stretches the result cycle.
// After reset and after a clear command the RAM is swept to zero, one entry a cycle,
// through every entry of the matrix, while no request is accepted.
// The output register lets new elements enter while a response waits to be taken.
module confusion_matrix_accumulator import cma_pkg::*; #(
   parameter int MAX_CLASSES = MAX_CLASSES_DEFAULT,
   parameter int COUNT_BITS  = COUNT_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data,
   cma_req_if.sink    req_ch,
   cma_rsp_if.source  rsp_ch
);

   localparam int DEPTH = MAX_CLASSES * MAX_CLASSES;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(MAX_CLASSES);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_RESULT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [4:0]            class_count_ff;
   logic [PW-1:0]         pos_ff, pos_in;
   logic signed [15:0]    best_score_ff, best_score_in;
   logic [PW-1:0]         best_idx_ff, best_idx_in;
   logic [PW-1:0]         hot_idx_ff, hot_idx_in;
   logic                  hot_seen_ff, hot_seen_in;
   logic [COUNT_BITS-1:0] correct_ff, correct_in;
   logic [COUNT_BITS-1:0] sample_ff, sample_in;

   logic                  res_kind_ff, res_kind_in;
   logic [PW-1:0]         res_best_ff, res_best_in;
   logic [PW-1:0]         res_hot_ff, res_hot_in;
   logic                  res_seen_ff, res_seen_in;
   logic                  res_inside_ff, res_inside_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  slot_free;
   logic [31:0]           eff_classes;
   logic                  take_max;
   logic [PW-1:0]         cand_best;
   logic [PW-1:0]         cand_hot;
   logic                  cand_seen;
   logic                  last_elem;
   logic                  read_inside;
   logic [31:0]           read_addr32;
   logic [31:0]           upd_addr32;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata;
   logic                  ram_re;
   logic [AW-1:0]         ram_raddr;
   logic [COUNT_BITS-1:0] ram_rdata;
   logic [COUNT_BITS-1:0] cell_inc;
   logic [COUNT_BITS-1:0] cell_val;
   logic [COUNT_BITS-1:0] correct_upd;
   logic [COUNT_BITS-1:0] sample_upd;
   logic [31:0]           cell_ext, correct_ext, sample_ext;

   cma_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   always_comb begin
      if (32'(class_count_ff) < 32'd2) begin
         eff_classes = 32'd2;
      end else if (32'(class_count_ff) > 32'(MAX_CLASSES)) begin
         eff_classes = 32'(MAX_CLASSES);
      end else begin
         eff_classes = 32'(class_count_ff);
      end
   end

   assign take_max  = (pos_ff == '0) || (req_ch.data.score > best_score_ff);
   assign cand_best = take_max ? pos_ff : best_idx_ff;
   assign cand_seen = hot_seen_ff || req_ch.data.label_hot;
   assign cand_hot  = (req_ch.data.label_hot && !hot_seen_ff) ? pos_ff : hot_idx_ff;
   assign last_elem = (32'(pos_ff) + 32'd1) >= eff_classes;

   assign read_inside = (32'(req_ch.data.read_row) < 32'(MAX_CLASSES)) &&
                        (32'(req_ch.data.read_col) < 32'(MAX_CLASSES));
   assign read_addr32 = 32'(req_ch.data.read_row) * 32'(MAX_CLASSES) +
                        32'(req_ch.data.read_col);
   assign upd_addr32  = 32'(res_hot_ff) * 32'(MAX_CLASSES) + 32'(res_best_ff);

   assign cell_inc    = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
   assign correct_upd = (correct_ff == '1) ? correct_ff : correct_ff + 1'b1;
   assign sample_upd  = (sample_ff == '1) ? sample_ff : sample_ff + 1'b1;

   always_comb begin
      ram_re    = 1'b0;
      ram_raddr = AW'(upd_addr32);
      ram_we    = 1'b0;
      ram_waddr = AW'(upd_addr32);
      ram_wdata = cell_inc;
      if (accept && req_ch.data.cmd == CMD_READ) begin
         ram_re    = read_inside;
         ram_raddr = AW'(read_addr32);
      end else if (accept && req_ch.data.cmd == CMD_SAMPLE && last_elem) begin
         ram_re    = cand_seen;
         ram_raddr = AW'(32'(cand_hot) * 32'(MAX_CLASSES) + 32'(cand_best));
      end
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (state_ff == ST_RESULT && slot_free && res_kind_ff == KIND_SAMPLE) begin
         ram_we = res_seen_ff;
      end
   end

   always_comb begin
      if (res_kind_ff == KIND_SAMPLE) begin
         cell_val = res_seen_ff ? cell_inc : '0;
      end else begin
         cell_val = res_inside_ff ? ram_rdata : '0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      pos_in        = pos_ff;
      best_score_in = best_score_ff;
      best_idx_in   = best_idx_ff;
      hot_idx_in    = hot_idx_ff;
      hot_seen_in   = hot_seen_ff;
      correct_in    = correct_ff;
      sample_in     = sample_ff;
      res_kind_in   = res_kind_ff;
      res_best_in   = res_best_ff;
      res_hot_in    = res_hot_ff;
      res_seen_in   = res_seen_ff;
      res_inside_in = res_inside_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      correct_ext   = 32'(correct_ff);
      sample_ext    = 32'(sample_ff);
      cell_ext      = 32'(cell_val);

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_ch.data.cmd)
                  CMD_SAMPLE: begin
                     if (last_elem) begin
                        res_kind_in   = KIND_SAMPLE;
                        res_best_in   = cand_best;
                        res_hot_in    = cand_hot;
                        res_seen_in   = cand_seen;
                        state_in      = ST_RESULT;
                        pos_in        = '0;
                        best_score_in = '0;
                        best_idx_in   = '0;
                        hot_idx_in    = '0;
                        hot_seen_in   = 1'b0;
                     end else begin
                        pos_in        = pos_ff + 1'b1;
                        best_score_in = take_max ? req_ch.data.score : best_score_ff;
                        best_idx_in   = cand_best;
                        hot_idx_in    = cand_hot;
                        hot_seen_in   = cand_seen;
                     end
                  end
                  CMD_READ: begin
                     res_kind_in   = KIND_CELL;
                     res_inside_in = read_inside;
                     state_in      = ST_RESULT;
                  end
                  CMD_CLEAR: begin
                     correct_in    = '0;
                     sample_in     = '0;
                     pos_in        = '0;
                     best_score_in = '0;
                     best_idx_in   = '0;
                     hot_idx_in    = '0;
                     hot_seen_in   = 1'b0;
                     clr_in        = '0;
                     state_in      = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RESULT: begin
            if (slot_free) begin
               if (res_kind_ff == KIND_SAMPLE) begin
                  sample_in  = sample_upd;
                  sample_ext = 32'(sample_upd);
                  if (res_seen_ff && res_hot_ff == res_best_ff) begin
                     correct_in  = correct_upd;
                     correct_ext = 32'(correct_upd);
                  end
               end
               rsp_valid_in                = 1'b1;
               rsp_data_in.kind            = res_kind_ff;
               rsp_data_in.predicted_index = (res_kind_ff == KIND_SAMPLE) ?
                                             4'(res_best_ff) : 4'd0;
               rsp_data_in.label_index     = (res_kind_ff == KIND_SAMPLE && res_seen_ff) ?
                                             4'(res_hot_ff) : 4'd0;
               rsp_data_in.label_valid     = (res_kind_ff == KIND_SAMPLE) && res_seen_ff;
               rsp_data_in.cell_count      = (cell_ext > 32'hFFFF) ? 16'hFFFF
                                                                  : cell_ext[15:0];
               rsp_data_in.correct_total   = (correct_ext > 32'hFFFF) ? 16'hFFFF
                                                                     : correct_ext[15:0];
               rsp_data_in.sample_total    = (sample_ext > 32'hFFFF) ? 16'hFFFF
                                                                    : sample_ext[15:0];
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         pos_in        = '0;
         best_score_in = '0;
         best_idx_in   = '0;
         hot_idx_in    = '0;
         hot_seen_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         class_count_ff <= CLASS_COUNT_RESET;
         pos_ff         <= '0;
         best_score_ff  <= '0;
         best_idx_ff    <= '0;
         hot_idx_ff     <= '0;
         hot_seen_ff    <= 1'b0;
         correct_ff     <= '0;
         sample_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pos_ff        <= pos_in;
         best_score_ff <= best_score_in;
         best_idx_ff   <= best_idx_in;
         hot_idx_ff    <= hot_idx_in;
         hot_seen_ff   <= hot_seen_in;
         correct_ff    <= correct_in;
         sample_ff     <= sample_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            class_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_kind_ff   <= res_kind_in;
      res_best_ff   <= res_best_in;
      res_hot_ff    <= res_hot_in;
      res_seen_ff   <= res_seen_in;
      res_inside_ff <= res_inside_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule
